### design/assert_macros.svh
// Assertion macros shared by the SHA-1 digest design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SHA1_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Same-cycle implication, disabled while reset is asserted.
`define SHA1_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### design/sha1_pkg.sv
// Types, constants and helper functions of the SHA-1 digest design.
`default_nettype none

package sha1_pkg;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [0:BLOCK_BYTES-1][7:0] sha1_block_t;
	typedef logic [0:4][31:0] sha1_chain_t;
	typedef logic [0:15][31:0] sha1_sched_t;

	typedef struct packed {
		sha1_block_t bytes;
		logic        is_last;
	} sha1_qent_t;

	localparam logic [0:3][31:0] SHA1_K = {
		32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
	};

	localparam sha1_chain_t SHA1_IV = {
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

	function automatic logic [31:0] rotl5(input logic [31:0] x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] x);
		return {x[1:0], x[31:2]};
	endfunction

endpackage

`default_nettype wire

### design/sha1_stream_if.sv
// Valid/ready channel interfaces for message bytes and digest results.
`default_nettype none

interface sha1_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, data_byte, has_byte, last, input ready);
	modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha1_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_a;
	logic [31:0] digest_b;
	logic [31:0] digest_c;
	logic [31:0] digest_d;
	logic [31:0] digest_e;

	modport source (output valid, digest_a, digest_b, digest_c, digest_d, digest_e,
		input ready);
	modport sink (input valid, digest_a, digest_b, digest_c, digest_d, digest_e,
		output ready);
endinterface

`default_nettype wire

### design/sha1_front.sv
// Byte packer and padding generator that hands complete blocks to the queue.
`default_nettype none

module sha1_front
	import sha1_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	sha1_msg_if.sink    msg,
	output logic        push_valid,
	input  wire logic   push_ready,
	output sha1_qent_t  push_data
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_FULL = 4'b0010,
		F_PAD  = 4'b0100,
		F_LEN  = 4'b1000
	} front_state_t;

	front_state_t state_q;
	sha1_block_t  blk_q;
	sha1_block_t  pad_blk;
	sha1_block_t  len_blk;
	logic [5:0]   pos_q;
	logic [60:0]  len_q;
	logic         pad_q;
	logic [63:0]  bit_len;
	logic         acc;
	logic         fits;

	assign acc = msg.valid && msg.ready;
	assign msg.ready = (state_q == F_IDLE);
	assign bit_len = {len_q, 3'b000};
	assign fits = (pos_q < LEN_POS);

	always_comb begin
		pad_blk = '0;
		len_blk = '0;
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			if (6'(i) < pos_q) begin
				pad_blk[i] = blk_q[i];
			end else if (6'(i) == pos_q) begin
				pad_blk[i] = PAD_BYTE;
			end
		end
		for (int k = 0; k < 8; k++) begin
			len_blk[56 + k] = bit_len[63 - 8 * k -: 8];
			if (fits) begin
				pad_blk[56 + k] = bit_len[63 - 8 * k -: 8];
			end
		end
	end

	always_comb begin
		push_valid = 1'b0;
		push_data.bytes = blk_q;
		push_data.is_last = 1'b0;
		unique case (state_q)
			F_IDLE: begin
			end
			F_FULL: begin
				push_valid = 1'b1;
			end
			F_PAD: begin
				push_valid = 1'b1;
				push_data.bytes = pad_blk;
				push_data.is_last = fits;
			end
			F_LEN: begin
				push_valid = 1'b1;
				push_data.bytes = len_blk;
				push_data.is_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc && msg.has_byte) begin
			blk_q[pos_q] <= msg.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pos_q <= '0;
			len_q <= '0;
			pad_q <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (acc) begin
						if (msg.has_byte) begin
							len_q <= len_q + 1'b1;
							pos_q <= pos_q + 1'b1;
							if (pos_q == LAST_POS) begin
								state_q <= F_FULL;
								pad_q <= msg.last;
							end else if (msg.last) begin
								state_q <= F_PAD;
							end
						end else if (msg.last) begin
							state_q <= F_PAD;
						end
					end
				end
				F_FULL: begin
					if (push_ready) begin
						state_q <= pad_q ? F_PAD : F_IDLE;
						pad_q <= 1'b0;
					end
				end
				F_PAD: begin
					if (push_ready) begin
						if (fits) begin
							state_q <= F_IDLE;
							pos_q <= '0;
							len_q <= '0;
						end else begin
							state_q <= F_LEN;
						end
					end
				end
				F_LEN: begin
					if (push_ready) begin
						state_q <= F_IDLE;
						pos_q <= '0;
						len_q <= '0;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### design/sha1_queue.sv
// Short block queue between the byte packer and the compression engine.
`default_nettype none

`include "assert_macros.svh"

module sha1_queue
	import sha1_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push_valid,
	output logic             push_ready,
	input  wire sha1_qent_t  push_data,
	output logic             pop_valid,
	input  wire logic        pop_ready,
	output sha1_qent_t       pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sha1_qent_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign push_fire = push_valid && push_ready;
	assign pop_fire = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop_fire) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`SHA1_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "queue count exceeds depth")
	`SHA1_ASSERT(a_cnt_up, (push_fire && !pop_fire) |=> (cnt_q == $past(cnt_q) + 1'b1), "queue count did not grow on push")
	`SHA1_ASSERT_IMPL(a_empty_ptr, cnt_q == '0, wr_ptr_q == rd_ptr_q, "empty queue with split pointers")

endmodule

`default_nettype wire

### design/sha1_back.sv
// Compression engine: 80 rounds per block, chaining value and digest register.
`default_nettype none

`include "assert_macros.svh"

module sha1_back
	import sha1_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pop_valid,
	output logic             pop_ready,
	input  wire sha1_qent_t  pop_data,
	sha1_digest_if.source    digest
);

	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_ROUND = 3'b010,
		B_ADD   = 3'b100
	} back_state_t;

	back_state_t state_q;
	sha1_sched_t w_q;
	sha1_chain_t chain_q;
	sha1_chain_t sum;
	sha1_chain_t dig_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic        last_q;
	logic        out_valid_q;
	logic [1:0]  stage;
	logic [31:0] f;
	logic [31:0] tmp;
	logic        fin_ok;
	logic        fold_last;
	logic        out_fire;

	assign pop_ready = (state_q == B_IDLE);
	assign out_fire = out_valid_q && digest.ready;
	assign fin_ok = !last_q || !out_valid_q || digest.ready;
	assign fold_last = (state_q == B_ADD) && last_q && fin_ok;

	assign digest.valid = out_valid_q;
	assign digest.digest_a = dig_q[0];
	assign digest.digest_b = dig_q[1];
	assign digest.digest_c = dig_q[2];
	assign digest.digest_d = dig_q[3];
	assign digest.digest_e = dig_q[4];

	always_comb begin
		if (rnd_q < 7'd20) begin
			stage = 2'd0;
		end else if (rnd_q < 7'd40) begin
			stage = 2'd1;
		end else if (rnd_q < 7'd60) begin
			stage = 2'd2;
		end else begin
			stage = 2'd3;
		end
		case (stage)
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd2: f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			default: f = b_q ^ c_q ^ d_q;
		endcase
		tmp = rotl5(a_q) + f + e_q + w_q[0] + SHA1_K[stage];
	end

	assign sum[0] = chain_q[0] + a_q;
	assign sum[1] = chain_q[1] + b_q;
	assign sum[2] = chain_q[2] + c_q;
	assign sum[3] = chain_q[3] + d_q;
	assign sum[4] = chain_q[4] + e_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				for (int j = 0; j < 16; j++) begin
					w_q[j] <= {pop_data.bytes[4 * j], pop_data.bytes[4 * j + 1],
						pop_data.bytes[4 * j + 2], pop_data.bytes[4 * j + 3]};
				end
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
				e_q <= chain_q[4];
			end
			B_ROUND: begin
				for (int j = 0; j < 15; j++) begin
					w_q[j] <= w_q[j + 1];
				end
				w_q[15] <= rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);
				e_q <= d_q;
				d_q <= c_q;
				c_q <= rotl30(b_q);
				b_q <= a_q;
				a_q <= tmp;
			end
			B_ADD: begin
				if (fin_ok && last_q) begin
					dig_q <= sum;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			chain_q <= SHA1_IV;
			rnd_q <= '0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fold_last) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						state_q <= B_ROUND;
						rnd_q <= '0;
						last_q <= pop_data.is_last;
					end
				end
				B_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= B_ADD;
					end
				end
				B_ADD: begin
					if (fin_ok) begin
						state_q <= B_IDLE;
						if (last_q) begin
							chain_q <= SHA1_IV;
						end else begin
							chain_q <= sum;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	`SHA1_ASSERT_IMPL(a_rnd_range, state_q == B_ROUND, rnd_q <= LAST_ROUND, "round count out of range")
	`SHA1_ASSERT(a_out_src, $rose(out_valid_q) |-> $past(state_q == B_ADD), "digest not from fold")
	`SHA1_ASSERT(a_chain_iv, fold_last |=> (chain_q == SHA1_IV), "chaining value not restored")

endmodule

`default_nettype wire

### design/sha1_message_digest.sv
// Flow: a byte transaction is taken while the packer is idle; a block that fills holds off input
// until the queue takes it. The engine takes each 64-byte block through load, 80 rounds,
// and fold. The queue lets the packer take bytes of the next block while the engine works. The
// digest is registered at the fold of the final block, after any blocks still queued.
// Reset: arst_n clears control state and loads the SHA-1 initial chaining value at once.
`default_nettype none

module sha1_message_digest
	import sha1_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sha1_msg_if.sink      msg,
	sha1_digest_if.source digest
);

	logic       push_valid;
	logic       push_ready;
	sha1_qent_t push_data;
	logic       pop_valid;
	logic       pop_ready;
	sha1_qent_t pop_data;

	sha1_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sha1_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sha1_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.digest    (digest)
	);

endmodule

`default_nettype wire

### tb/sha1_message_digest_tb.sv
// Self-checking testbench that streams byte messages into the digest block and checks results.
`default_nettype none

module sha1_message_digest_tb;
	import sha1_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0]  data_byte;
		logic        has_byte;
		logic        last;
		int unsigned gap;
		bit          drain;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} digest_t;

	logic clk = 1'b0;
	logic arst_n;

	sha1_msg_if    msg_ch();
	sha1_digest_if dig_ch();

	sha1_message_digest DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	msg_item_t   pending_items[$];
	digest_t     digests_due[$];
	int unsigned mismatch_count = 0;
	int unsigned counted_items = 0;
	int unsigned message_count = 0;

	logic [31:0] sha_block [0:15];
	sha1_chain_t sha_chain;
	logic [60:0] sha_msg_len;
	logic [5:0]  sha_fill;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic int unsigned draw_wait(input bit burst);
		if (burst || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	task automatic sha_clear();
		for (int i = 0; i < 16; i++)
			sha_block[i] = 32'h0;
		sha_chain = SHA1_IV;
		sha_msg_len = '0;
		sha_fill = '0;
	endtask

	task automatic sha_compress();
		logic [31:0] w [0:79];
		logic [31:0] a, b, c, d, e, f, tmp;
		for (int i = 0; i < 16; i++)
			w[i] = sha_block[i];
		for (int i = 16; i < 80; i++)
			w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = sha_chain[0];
		b = sha_chain[1];
		c = sha_chain[2];
		d = sha_chain[3];
		e = sha_chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20)
				f = (b & c) | (~b & d);
			else if (i >= 40 && i < 60)
				f = (b & c) | (b & d) | (c & d);
			else
				f = b ^ c ^ d;
			tmp = rol32(a, 5) + f + e + w[i] + SHA1_K[i / 20];
			e = d;
			d = c;
			c = rol32(b, 30);
			b = a;
			a = tmp;
		end
		sha_chain[0] = sha_chain[0] + a;
		sha_chain[1] = sha_chain[1] + b;
		sha_chain[2] = sha_chain[2] + c;
		sha_chain[3] = sha_chain[3] + d;
		sha_chain[4] = sha_chain[4] + e;
	endtask

	task automatic sha_put(input logic [7:0] value);
		if (sha_fill[1:0] == 2'd0)
			sha_block[sha_fill[5:2]] = 32'h0;
		sha_block[sha_fill[5:2]][8 * (3 - sha_fill[1:0]) +: 8] = value;
		sha_fill = sha_fill + 6'd1;
		if (sha_fill == 6'd0)
			sha_compress();
	endtask

	task automatic sha_take(input msg_item_t it);
		logic [63:0] bit_len;
		digest_t     dg;
		if (it.has_byte) begin
			sha_put(it.data_byte);
			sha_msg_len = sha_msg_len + 61'd1;
		end
		if (it.last) begin
			bit_len = {sha_msg_len, 3'b000};
			sha_put(PAD_BYTE);
			while (sha_fill != LEN_POS)
				sha_put(8'h00);
			for (int k = 0; k < 8; k++)
				sha_put(bit_len[63 - 8 * k -: 8]);
			dg.a = sha_chain[0];
			dg.b = sha_chain[1];
			dg.c = sha_chain[2];
			dg.d = sha_chain[3];
			dg.e = sha_chain[4];
			digests_due.push_back(dg);
			sha_clear();
		end
	endtask

	task automatic push_item(input logic [7:0] data_byte, input logic has_byte,
		input logic last, input bit burst, input bit drain);
		msg_item_t it;
		it.data_byte = data_byte;
		it.has_byte = has_byte;
		it.last = last;
		it.gap = draw_wait(burst);
		it.drain = drain;
		pending_items.push_back(it);
		if (has_byte || last)
			counted_items++;
		if (last)
			message_count++;
	endtask

	// Driver: presents queued items after their idle gap and predicts each accepted transaction.
	msg_item_t   cur_item;
	bit          have_item = 1'b0;
	bit          shown = 1'b0;
	int unsigned gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_ch.valid <= 1'b0;
			msg_ch.data_byte <= 8'h00;
			msg_ch.has_byte <= 1'b0;
			msg_ch.last <= 1'b0;
			have_item = 1'b0;
			shown = 1'b0;
			gap_left = 0;
		end else begin
			if (msg_ch.valid && msg_ch.ready) begin
				sha_take(cur_item);
				have_item = 1'b0;
				shown = 1'b0;
			end
			if (!have_item && pending_items.size() > 0) begin
				cur_item = pending_items.pop_front();
				have_item = 1'b1;
				gap_left = cur_item.gap;
			end
			if (have_item && !shown) begin
				if (gap_left > 0)
					gap_left--;
				else if (!cur_item.drain || digests_due.size() == 0)
					shown = 1'b1;
			end
			msg_ch.valid <= shown;
			msg_ch.data_byte <= cur_item.data_byte;
			msg_ch.has_byte <= cur_item.has_byte;
			msg_ch.last <= cur_item.last;
		end
	end

	// Monitor: stalls at random and compares each digest transaction with the oldest prediction.
	int unsigned stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (dig_ch.valid && dig_ch.ready) begin
				if (digests_due.size() == 0) begin
					$error("digest: unexpected result %h %h %h %h %h", dig_ch.digest_a,
						dig_ch.digest_b, dig_ch.digest_c, dig_ch.digest_d, dig_ch.digest_e);
					mismatch_count++;
				end else begin
					digest_t exp_dg;
					exp_dg = digests_due.pop_front();
					if (dig_ch.digest_a !== exp_dg.a) begin
						$error("digest_a: expected %h, actual %h", exp_dg.a, dig_ch.digest_a);
						mismatch_count++;
					end
					if (dig_ch.digest_b !== exp_dg.b) begin
						$error("digest_b: expected %h, actual %h", exp_dg.b, dig_ch.digest_b);
						mismatch_count++;
					end
					if (dig_ch.digest_c !== exp_dg.c) begin
						$error("digest_c: expected %h, actual %h", exp_dg.c, dig_ch.digest_c);
						mismatch_count++;
					end
					if (dig_ch.digest_d !== exp_dg.d) begin
						$error("digest_d: expected %h, actual %h", exp_dg.d, dig_ch.digest_d);
						mismatch_count++;
					end
					if (dig_ch.digest_e !== exp_dg.e) begin
						$error("digest_e: expected %h, actual %h", exp_dg.e, dig_ch.digest_e);
						mismatch_count++;
					end
				end
				stall_left = draw_wait(1'b0);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			dig_ch.ready <= (stall_left == 0);
		end
	end

	initial begin
		int unsigned len;
		int unsigned pick;
		bit          burst;
		bit          byte_on_last;
		int unsigned boundary_lens [9];

		boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.data_byte = 8'h00;
		msg_ch.has_byte = 1'b0;
		msg_ch.last = 1'b0;
		dig_ch.ready = 1'b0;
		sha_clear();

		// Directed part: idle item, empty message, byte extremes, abc, abc with a byte-less last, and an idle gap.
		push_item($urandom_range(0, 255), 1'b0, 1'b0, 1'b0, 1'b0);
		push_item($urandom_range(0, 255), 1'b0, 1'b1, 1'b0, 1'b0);
		push_item(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
		push_item(8'hff, 1'b1, 1'b1, 1'b0, 1'b0);
		push_item(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
		push_item(8'h62, 1'b1, 1'b0, 1'b0, 1'b0);
		push_item(8'h63, 1'b1, 1'b1, 1'b0, 1'b0);
		push_item(8'h61, 1'b1, 1'b0, 1'b1, 1'b0);
		push_item(8'h62, 1'b1, 1'b0, 1'b1, 1'b0);
		push_item(8'h63, 1'b1, 1'b0, 1'b1, 1'b0);
		push_item(8'hff, 1'b0, 1'b1, 1'b1, 1'b0);
		push_item(8'h55, 1'b1, 1'b0, 1'b0, 1'b0);
		push_item(8'h5a, 1'b0, 1'b0, 1'b0, 1'b0);
		push_item(8'haa, 1'b1, 1'b1, 1'b0, 1'b0);

		while (counted_items < 1300 || message_count < 40) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				len = $urandom_range(0, 20);
			else if (pick < 8)
				len = boundary_lens[$urandom_range(0, 8)];
			else
				len = $urandom_range(0, 200);
			burst = ($urandom_range(0, 4) == 0);
			byte_on_last = (len > 0) && $urandom_range(0, 1);
			for (int i = 0; i < len; i++) begin
				if (!burst && $urandom_range(0, 15) == 0)
					push_item($urandom_range(0, 255), 1'b0, 1'b0, 1'b0, 1'b0);
				push_item($urandom_range(0, 255), 1'b1, byte_on_last && (i == len - 1),
					burst, (i == 0) && (message_count == 4 || $urandom_range(0, 7) == 0));
			end
			if (!byte_on_last)
				push_item($urandom_range(0, 255), 1'b0, 1'b1, burst,
					(len == 0) && $urandom_range(0, 7) == 0);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_items.size() == 0 && !have_item);
		wait (digests_due.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0)
			$display("sha1_message_digest_tb: PASS");
		else
			$display("sha1_message_digest_tb: FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("sha1_message_digest_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/sha1_pkg.sv
design/sha1_stream_if.sv
design/sha1_front.sv
design/sha1_queue.sv
design/sha1_back.sv
design/sha1_message_digest.sv
tb/sha1_message_digest_tb.sv
